// File: rtl/vfv_pkg.sv
// Shared types, field widths and codes for the voxel face visibility block.
package vfv_pkg;

  localparam int REQ_W   = 1;
  localparam int X_W     = 3;
  localparam int Y_W     = 3;
  localparam int Z_W     = 5;
  localparam int COLOR_W = 2;
  localparam int MASK_W  = 6;
  localparam int COUNT_W = 3;

  typedef enum logic [REQ_W-1:0] {
    REQ_WRITE = 1'b0,
    REQ_QUERY = 1'b1
  } req_t;

  localparam logic [COLOR_W-1:0] COLOR_EMPTY = '0;

  localparam int FACE_LEFT   = 0;
  localparam int FACE_RIGHT  = 1;
  localparam int FACE_TOP    = 2;
  localparam int FACE_BOTTOM = 3;
  localparam int FACE_FRONT  = 4;
  localparam int FACE_BACK   = 5;

  // Banks are selected by {y parity, z parity}, relative to the addressed voxel.
  localparam int BANKS = 4;
  localparam logic [1:0] BANK_CENTER = 2'b00;
  localparam logic [1:0] BANK_Z_NBR  = 2'b01;
  localparam logic [1:0] BANK_Y_NBR  = 2'b10;

  typedef struct packed {
    logic               is_query;
    logic               in_grid;
    logic [X_W-1:0]     x;
    logic [COLOR_W-1:0] color;
    logic               has_up;
    logic               has_down;
    logic               has_front;
    logic               has_back;
  } face_ctl_t;

  function automatic logic [COUNT_W-1:0] face_popcount(input logic [MASK_W-1:0] m);
    logic [COUNT_W-1:0] n;
    n = '0;
    for (int i = 0; i < MASK_W; i++) begin
      n = n + COUNT_W'(m[i]);
    end
    return n;
  endfunction

endpackage

// File: rtl/vfv_bank.sv
// One bank of voxel rows: one write port with row clear, two registered read ports.
module vfv_bank
  import vfv_pkg::*;
#(
  parameter int ROW_LEN = 8,
  parameter int DEPTH   = 16,
  parameter int AW      = 4,
  parameter int XW      = 3
) (
  input  logic                              clk,
  input  logic                              clr,
  input  logic                              we,
  input  logic [AW-1:0]                     waddr,
  input  logic [XW-1:0]                     wsel,
  input  logic [COLOR_W-1:0]                wcolor,
  input  logic [AW-1:0]                     raddr_a,
  input  logic [AW-1:0]                     raddr_b,
  output logic [ROW_LEN-1:0][COLOR_W-1:0]   rdata_a,
  output logic [ROW_LEN-1:0][COLOR_W-1:0]   rdata_b
);

  logic [ROW_LEN-1:0][COLOR_W-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (clr) begin
      mem[waddr] <= '0;
    end else if (we) begin
      mem[waddr][wsel] <= wcolor;
    end
  end

  always_ff @(posedge clk) begin
    rdata_a <= mem[raddr_a];
    rdata_b <= mem[raddr_b];
  end

endmodule

// File: rtl/vfv_face.sv
// Exposed-face mask, face count and colour from the fetched center and neighbor rows.
module vfv_face
  import vfv_pkg::*;
#(
  parameter int GRID_WIDTH = 8,
  parameter int XW         = 3
) (
  input  face_ctl_t                           ctl,
  input  logic [GRID_WIDTH-1:0][COLOR_W-1:0]  c_row,
  input  logic [GRID_WIDTH-1:0][COLOR_W-1:0]  up_row,
  input  logic [GRID_WIDTH-1:0][COLOR_W-1:0]  down_row,
  input  logic [GRID_WIDTH-1:0][COLOR_W-1:0]  front_row,
  input  logic [GRID_WIDTH-1:0][COLOR_W-1:0]  back_row,
  output logic [MASK_W-1:0]                   mask,
  output logic [COUNT_W-1:0]                  count,
  output logic [COLOR_W-1:0]                  color
);

  logic          has_left;
  logic          has_right;
  logic [XW-1:0] idx_c;
  logic [XW-1:0] idx_l;
  logic [XW-1:0] idx_r;
  logic          solid;

  always_comb begin
    has_left  = int'(ctl.x) != 0;
    has_right = int'(ctl.x) + 1 < GRID_WIDTH;
    idx_c     = XW'(ctl.x);
    idx_l     = has_left  ? XW'(int'(ctl.x) - 1) : idx_c;
    idx_r     = has_right ? XW'(int'(ctl.x) + 1) : idx_c;

    if (!ctl.in_grid) begin
      color = COLOR_EMPTY;
    end else if (ctl.is_query) begin
      color = c_row[idx_c];
    end else begin
      color = ctl.color;
    end

    solid = ctl.in_grid && ctl.is_query && (color != COLOR_EMPTY);
    mask  = '0;
    if (solid) begin
      mask[FACE_LEFT]   = !has_left      || (c_row[idx_l]     == COLOR_EMPTY);
      mask[FACE_RIGHT]  = !has_right     || (c_row[idx_r]     == COLOR_EMPTY);
      mask[FACE_TOP]    = !ctl.has_up    || (up_row[idx_c]    == COLOR_EMPTY);
      mask[FACE_BOTTOM] = !ctl.has_down  || (down_row[idx_c]  == COLOR_EMPTY);
      mask[FACE_FRONT]  = !ctl.has_front || (front_row[idx_c] == COLOR_EMPTY);
      mask[FACE_BACK]   = !ctl.has_back  || (back_row[idx_c]  == COLOR_EMPTY);
    end
    count = face_popcount(mask);
  end

endmodule

// File: rtl/voxel_face_visibility.sv
// Voxel face visibility: voxel grid store with per-voxel exposed-face query.
//
// Input beat: taken at a rising edge with start high and busy low. req_type
// selects a colour write at (pos_x, pos_y, pos_z) or a face query there.
// Result beat: face_mask, face_count and voxel_color are valid for exactly
// one cycle while done is high; the receiver cannot stall the block.
// Pipeline: done rises from the result register, which follows the grid read
// register. Throughput: one beat every cycle, back to back, while busy is low.
// Storage: rows of GRID_WIDTH voxels split over four banks by y and z parity,
// so a query fetches the center row and its four neighbor rows with at most
// two reads per bank in one cycle; left and right come from the center row.
// A write lands at its accept edge, so a query in the next cycle sees it.
// Reset: the grid is cleared by a pass of one row per bank per cycle over
// all ceil(GRID_HEIGHT/2) * ceil(GRID_DEPTH/2) rows of each bank (64 at the
// default size), with busy high throughout. Positions outside the grid write
// nothing and return all-zero results.
module voxel_face_visibility
  import vfv_pkg::*;
#(
  parameter int GRID_WIDTH  = 8,
  parameter int GRID_HEIGHT = 8,
  parameter int GRID_DEPTH  = 32
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               start,
  output logic               busy,
  input  logic [REQ_W-1:0]   req_type,
  input  logic [X_W-1:0]     pos_x,
  input  logic [Y_W-1:0]     pos_y,
  input  logic [Z_W-1:0]     pos_z,
  input  logic [COLOR_W-1:0] new_color,
  output logic               done,
  output logic [MASK_W-1:0]  face_mask,
  output logic [COUNT_W-1:0] face_count,
  output logic [COLOR_W-1:0] voxel_color
);

  localparam int XW     = $clog2(GRID_WIDTH);
  localparam int Y_HALF = (GRID_HEIGHT + 1) / 2;
  localparam int Z_HALF = (GRID_DEPTH + 1) / 2;
  localparam int DEPTH  = Y_HALF * Z_HALF;
  localparam int AW     = (DEPTH > 1) ? $clog2(DEPTH) : 1;

  typedef logic [GRID_WIDTH-1:0][COLOR_W-1:0] row_t;

  function automatic logic [AW-1:0] row_addr(input int yv, input int zv);
    int a;
    if (yv < 0 || yv >= GRID_HEIGHT || zv < 0 || zv >= GRID_DEPTH) begin
      a = 0;
    end else begin
      a = (yv >>> 1) * Z_HALF + (zv >>> 1);
    end
    return AW'(a);
  endfunction

  logic            clearing;
  logic            clearing_next;
  logic [AW-1:0]   clr_addr;
  logic [AW-1:0]   clr_addr_next;

  logic            accept;
  logic            in_grid;
  logic [1:0]      cur_bank;
  logic [AW-1:0]   addr_c;
  logic [AW-1:0]   addr_up;
  logic [AW-1:0]   addr_down;
  logic [AW-1:0]   addr_front;
  logic [AW-1:0]   addr_back;
  face_ctl_t       ctl;

  logic            s1_valid;
  face_ctl_t       s1_ctl;
  logic [1:0]      s1_bank;

  row_t            rd_a [BANKS];
  row_t            rd_b [BANKS];

  logic [MASK_W-1:0]  f_mask;
  logic [COUNT_W-1:0] f_count;
  logic [COLOR_W-1:0] f_color;

  assign busy   = clearing;
  assign accept = start && !busy;

  always_comb begin
    clearing_next = clearing;
    clr_addr_next = clr_addr;
    if (clearing) begin
      clr_addr_next = clr_addr + AW'(1);
      if (clr_addr == AW'(DEPTH - 1)) begin
        clearing_next = 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      clearing <= 1'b1;
      clr_addr <= '0;
    end else begin
      clearing <= clearing_next;
      clr_addr <= clr_addr_next;
    end
  end

  always_comb begin
    in_grid    = (int'(pos_x) < GRID_WIDTH) && (int'(pos_y) < GRID_HEIGHT) &&
                 (int'(pos_z) < GRID_DEPTH);
    cur_bank   = {pos_y[0], pos_z[0]};
    addr_c     = row_addr(int'(pos_y), int'(pos_z));
    addr_up    = row_addr(int'(pos_y) - 1, int'(pos_z));
    addr_down  = row_addr(int'(pos_y) + 1, int'(pos_z));
    addr_front = row_addr(int'(pos_y), int'(pos_z) - 1);
    addr_back  = row_addr(int'(pos_y), int'(pos_z) + 1);

    ctl.is_query  = req_t'(req_type) == REQ_QUERY;
    ctl.in_grid   = in_grid;
    ctl.x         = pos_x;
    ctl.color     = new_color;
    ctl.has_up    = int'(pos_y) != 0;
    ctl.has_down  = int'(pos_y) + 1 < GRID_HEIGHT;
    ctl.has_front = int'(pos_z) != 0;
    ctl.has_back  = int'(pos_z) + 1 < GRID_DEPTH;
  end

  for (genvar k = 0; k < BANKS; k++) begin : g_bank
    logic [1:0]    rel;
    logic          we;
    logic [AW-1:0] waddr;
    logic [AW-1:0] raddr_a;
    logic [AW-1:0] raddr_b;

    always_comb begin
      rel     = 2'(k) ^ cur_bank;
      raddr_a = '0;
      raddr_b = '0;
      case (rel)
        BANK_CENTER: begin
          raddr_a = addr_c;
        end
        BANK_Y_NBR: begin
          raddr_a = addr_up;
          raddr_b = addr_down;
        end
        BANK_Z_NBR: begin
          raddr_a = addr_front;
          raddr_b = addr_back;
        end
        default: begin
          raddr_a = '0;
          raddr_b = '0;
        end
      endcase
      we    = accept && in_grid && !ctl.is_query && (rel == BANK_CENTER);
      waddr = clearing ? clr_addr : addr_c;
    end

    vfv_bank #(
      .ROW_LEN (GRID_WIDTH),
      .DEPTH   (DEPTH),
      .AW      (AW),
      .XW      (XW)
    ) u_bank (
      .clk     (clk),
      .clr     (clearing),
      .we      (we),
      .waddr   (waddr),
      .wsel    (XW'(pos_x)),
      .wcolor  (new_color),
      .raddr_a (raddr_a),
      .raddr_b (raddr_b),
      .rdata_a (rd_a[k]),
      .rdata_b (rd_b[k])
    );
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else begin
      s1_valid <= accept;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      s1_ctl  <= ctl;
      s1_bank <= cur_bank;
    end
  end

  vfv_face #(
    .GRID_WIDTH (GRID_WIDTH),
    .XW         (XW)
  ) u_face (
    .ctl       (s1_ctl),
    .c_row     (rd_a[s1_bank ^ BANK_CENTER]),
    .up_row    (rd_a[s1_bank ^ BANK_Y_NBR]),
    .down_row  (rd_b[s1_bank ^ BANK_Y_NBR]),
    .front_row (rd_a[s1_bank ^ BANK_Z_NBR]),
    .back_row  (rd_b[s1_bank ^ BANK_Z_NBR]),
    .mask      (f_mask),
    .count     (f_count),
    .color     (f_color)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      done <= 1'b0;
    end else begin
      done <= s1_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_valid) begin
      face_mask   <= f_mask;
      face_count  <= f_count;
      voxel_color <= f_color;
    end
  end

endmodule

// File: rtl/vfv_checker.sv
// Port-level checks for the voxel face visibility block, bound to its top level.
module vfv_checker
  import vfv_pkg::*;
(
  input logic               clk,
  input logic               rst,
  input logic               start,
  input logic               busy,
  input logic               done,
  input logic [MASK_W-1:0]  face_mask,
  input logic [COUNT_W-1:0] face_count,
  input logic [COLOR_W-1:0] voxel_color
);

  a_busy_after_reset: assert property (@(posedge clk)
    (!rst && $past(rst)) |-> busy)
    else $error("busy low right after reset");

  a_one_result_per_beat: assert property (@(posedge clk) disable iff (rst)
    (!$past(rst) && !$past(rst, 2)) |-> (done == $past(start && !busy, 2)))
    else $error("result strobe does not follow input beat by two cycles");

  a_count_matches_mask: assert property (@(posedge clk) disable iff (rst)
    done |-> (face_count == COUNT_W'($countones(face_mask))))
    else $error("face count differs from mask population");

  a_empty_has_no_faces: assert property (@(posedge clk) disable iff (rst)
    (done && (face_mask != '0)) |-> (voxel_color != COLOR_EMPTY))
    else $error("exposed faces reported on an empty voxel");

endmodule

bind voxel_face_visibility vfv_checker u_vfv_checker (
  .clk         (clk),
  .rst         (rst),
  .start       (start),
  .busy        (busy),
  .done        (done),
  .face_mask   (face_mask),
  .face_count  (face_count),
  .voxel_color (voxel_color)
);
